/* design/upd_pkg.sv */
// Shared types, constants and character-class functions for the URL path decoder.
`timescale 1ns / 1ps
package upd_pkg;

	localparam int unsigned LEN_W = 12;
	localparam int unsigned DEFAULT_QUEUE_DEPTH = 4;
	localparam logic [LEN_W-1:0] MAX_LENGTH_RESET = 12'd128;

	localparam logic [1:0] KIND_CHAR    = 2'd0;
	localparam logic [1:0] KIND_END     = 2'd1;
	localparam logic [1:0] KIND_INVALID = 2'd2;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_QUEST = 8'h3F;
	localparam logic [7:0] CH_UNDER = 8'h5F;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UZ    = 8'h5A;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LF_HEX = 8'h66;
	localparam logic [7:0] CH_LZ    = 8'h7A;
	localparam logic [3:0] HEX_LETTER_OFFSET = 4'd9;

	typedef struct packed {
		logic [7:0] out_char;
		logic [1:0] kind;
		logic       last;
	} upd_result_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_0) && (c <= CH_9);
	endfunction

	function automatic logic is_hex(input logic [7:0] c);
		logic [7:0] lc;
		lc = c | 8'h20;
		return is_digit(c) || ((lc >= CH_LA) && (lc <= CH_LF_HEX));
	endfunction

	function automatic logic [3:0] hex_val(input logic [7:0] c);
		return is_digit(c) ? c[3:0] : (c[3:0] + HEX_LETTER_OFFSET);
	endfunction

	function automatic logic is_term(input logic [7:0] c);
		return (c == CH_NUL) || (c == CH_CR) || (c == CH_LF) || (c == CH_TAB) ||
			(c == CH_SPACE) || (c == CH_QUEST);
	endfunction

	function automatic logic is_plain(input logic [7:0] c);
		return is_digit(c) || ((c >= CH_LA) && (c <= CH_LZ)) ||
			((c >= CH_UA) && (c <= CH_UZ)) || (c == CH_UNDER) ||
			(c == CH_MINUS) || (c == CH_PLUS) || (c == CH_SLASH);
	endfunction

endpackage

/* design/upd_chan_if.sv */
// Valid/ready channel interfaces for the input characters and the decoded results.
`timescale 1ns / 1ps
interface upd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_in;
	logic       start_req;

	modport source (output valid, output char_in, output start_req, input ready);
	modport sink (input valid, input char_in, input start_req, output ready);
endinterface

interface upd_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_char;
	logic [1:0] kind;
	logic       last;

	modport source (output valid, output out_char, output kind, output last, input ready);
	modport sink (input valid, input out_char, input kind, input last, output ready);
endinterface

/* design/upd_front.sv */
// Front end: accepts characters, tracks decoder state and classifies each into a result.
`timescale 1ns / 1ps
module upd_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic [upd_pkg::LEN_W-1:0]  cfg_wr_data,
	upd_in_if.sink                     in_ch,
	input  logic                       room,
	output logic                       push,
	output upd_pkg::upd_result_t       push_data
);

	typedef enum logic [2:0] {
		MODE_STOPPED,
		MODE_NORMAL,
		MODE_DOT,
		MODE_PCT1,
		MODE_PCT2
	} mode_t;

	mode_t                      mode_q, mode_d, mode_eff;
	logic [3:0]                 nibble_q, nibble_d, nibble_eff;
	logic [upd_pkg::LEN_W-1:0]  space_q, space_d, space_eff;
	logic [upd_pkg::LEN_W-1:0]  max_length_q;
	logic                       accept;
	logic                       emit;
	logic [7:0]                 emit_char;
	logic [1:0]                 emit_kind;
	logic                       no_room;
	logic [7:0]                 c;

	assign in_ch.ready = room;
	assign accept = in_ch.valid && room;
	assign c = in_ch.char_in;

	always_comb begin
		mode_eff   = in_ch.start_req ? MODE_NORMAL : mode_q;
		nibble_eff = in_ch.start_req ? 4'd0 : nibble_q;
		space_eff  = in_ch.start_req ? max_length_q : space_q;
		no_room    = space_eff <= upd_pkg::LEN_W'(1);
		mode_d     = mode_eff;
		nibble_d   = nibble_eff;
		space_d    = space_eff;
		emit       = 1'b0;
		emit_char  = 8'd0;
		emit_kind  = upd_pkg::KIND_CHAR;
		unique case (mode_eff) inside
			MODE_PCT1: begin
				if (!upd_pkg::is_hex(c)) begin
					emit      = 1'b1;
					emit_kind = upd_pkg::KIND_INVALID;
				end else begin
					nibble_d = upd_pkg::hex_val(c);
					mode_d   = MODE_PCT2;
				end
			end
			MODE_PCT2: begin
				emit = 1'b1;
				if (!upd_pkg::is_hex(c)) begin
					emit_kind = upd_pkg::KIND_INVALID;
				end else begin
					emit_char = {nibble_eff, upd_pkg::hex_val(c)};
					mode_d    = MODE_NORMAL;
					space_d   = space_eff - upd_pkg::LEN_W'(1);
				end
			end
			MODE_NORMAL, MODE_DOT: begin
				mode_d = MODE_NORMAL;
				if (upd_pkg::is_term(c)) begin
					emit      = 1'b1;
					emit_kind = upd_pkg::KIND_END;
				end else if (c == upd_pkg::CH_DOT) begin
					emit = 1'b1;
					if ((mode_eff == MODE_DOT) || no_room) begin
						emit_kind = upd_pkg::KIND_INVALID;
					end else begin
						emit_char = c;
						mode_d    = MODE_DOT;
						space_d   = space_eff - upd_pkg::LEN_W'(1);
					end
				end else if (c == upd_pkg::CH_PCT) begin
					if (no_room) begin
						emit      = 1'b1;
						emit_kind = upd_pkg::KIND_INVALID;
					end else begin
						mode_d = MODE_PCT1;
					end
				end else begin
					emit = 1'b1;
					if (no_room || !upd_pkg::is_plain(c)) begin
						emit_kind = upd_pkg::KIND_INVALID;
					end else begin
						emit_char = c;
						space_d   = space_eff - upd_pkg::LEN_W'(1);
					end
				end
			end
			default: begin
				emit = 1'b0;
			end
		endcase
		if (emit && (emit_kind != upd_pkg::KIND_CHAR)) begin
			mode_d = MODE_STOPPED;
		end
	end

	assign push = accept && emit;
	assign push_data = '{out_char: emit_char, kind: emit_kind, last: 1'b1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_STOPPED;
			nibble_q     <= 4'd0;
			space_q      <= '0;
			max_length_q <= upd_pkg::MAX_LENGTH_RESET;
		end else begin
			if (cfg_wr_en) begin
				max_length_q <= cfg_wr_data;
			end
			if (accept) begin
				mode_q   <= mode_d;
				nibble_q <= nibble_d;
				space_q  <= space_d;
			end
		end
	end

endmodule

/* design/upd_queue.sv */
// Short result queue that decouples the front end from the output stage.
`timescale 1ns / 1ps
module upd_queue #(
	parameter int unsigned Depth = upd_pkg::DEFAULT_QUEUE_DEPTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  upd_pkg::upd_result_t  push_data,
	input  logic                  pop,
	output logic                  not_empty,
	output logic                  not_full,
	output upd_pkg::upd_result_t  head
);

	localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int unsigned CntW = $clog2(Depth + 1);

	upd_pkg::upd_result_t entries_q [Depth];
	logic [PtrW-1:0]      wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0]      count_q;

	assign not_empty = count_q != '0;
	assign not_full  = count_q != CntW'(Depth);
	assign head      = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CntW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CntW'(1);
			end
		end
	end

endmodule

/* design/upd_back.sv */
// Back end: output register that drains the queue onto the result channel.
`timescale 1ns / 1ps
module upd_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  not_empty,
	input  upd_pkg::upd_result_t  head,
	output logic                  pop,
	upd_out_if.source             out_ch
);

	logic                 valid_q;
	upd_pkg::upd_result_t data_q;

	assign pop = not_empty && (!valid_q || out_ch.ready);

	assign out_ch.valid    = valid_q;
	assign out_ch.out_char = data_q.out_char;
	assign out_ch.kind     = data_q.kind;
	assign out_ch.last     = data_q.last;

	always_ff @(posedge clk) begin
		if (pop) begin
			data_q <= head;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			valid_q <= 1'b0;
		end
	end

endmodule

/* design/url_path_percent_decoder_core.sv */
// Top level of the URL path percent decoder: front end, result queue and output stage.
//
// Characters of an encoded URL path enter on in_ch, one transaction per character;
// start_req marks the first character of a new path. Decoded bytes and end markers
// leave on out_ch, at most one transaction per input character, with last always set.
// The buffer size is written through cfg_wr_en and cfg_wr_data while the block is idle
// and takes effect at the next start character.
// Throughput is one character per cycle while the queue has room. A result is written
// into the queue at the edge that accepts its character and moves into the output
// register once that register is empty or its result is being taken by the receiver.
// Characters that produce nothing (the first hex digit of an escape, a percent sign,
// input while stopped) pass through the front end without using queue space.
// When the receiver stalls, results collect in the queue; in_ch.ready falls only once
// the queue is full, so the input side keeps flowing through short stalls.
// Reset clears the queue and output register, stops the decoder until the next start
// character and restores a buffer size of 128.
`timescale 1ns / 1ps
module url_path_percent_decoder_core #(
	parameter int unsigned QueueDepth = upd_pkg::DEFAULT_QUEUE_DEPTH
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wr_en,
	input  logic [upd_pkg::LEN_W-1:0] cfg_wr_data,
	upd_in_if.sink                    in_ch,
	upd_out_if.source                 out_ch
);

	logic                 push;
	logic                 pop;
	logic                 not_empty;
	logic                 not_full;
	upd_pkg::upd_result_t push_data;
	upd_pkg::upd_result_t head;

	upd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_ch       (in_ch),
		.room        (not_full),
		.push        (push),
		.push_data   (push_data)
	);

	upd_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.not_empty (not_empty),
		.not_full  (not_full),
		.head      (head)
	);

	upd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.not_empty (not_empty),
		.head      (head),
		.pop       (pop),
		.out_ch    (out_ch)
	);

	assert property (@(posedge clk) disable iff (!arst_n) push |-> not_full)
		else $error("result pushed into a full queue");

	assert property (@(posedge clk) disable iff (!arst_n) pop |-> not_empty)
		else $error("result popped from an empty queue");

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && (out_ch.kind != upd_pkg::KIND_CHAR)) |-> (out_ch.out_char == 8'd0))
		else $error("end or invalid marker carries a non-zero byte");

	assert property (@(posedge clk) disable iff (!arst_n) out_ch.valid |-> out_ch.last)
		else $error("result transaction without last set");

endmodule
